FILE: rtl/core/gqyi_pkg.sv
// Shared types and constants of the gyro quaternion yaw integrator.
package gqyi_pkg;

  // Number of CORDIC vectoring steps for the yaw angle (12 to 32).
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic [63:0]        NORM_SQ_MIN = 64'd11529215047;
  localparam logic signed [24:0] YAW_MAX     = 25'sd11796480;
  localparam logic signed [24:0] YAW_90      = 25'sd5898240;
  localparam logic signed [33:0] DEG90_Q24   = 34'sd1509949440;

  // atan(2^-i) in units of 1/2^24 degree.
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd754974720, 30'd445687601, 30'd235489089, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Request to the shared bit-serial multiplier.
  typedef struct packed {
    logic               start;
    logic signed [37:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  // Response of the multiplier: done pulses for one cycle with the product.
  typedef struct packed {
    logic               done;
    logic signed [69:0] p;
  } mul_rsp_t;

endpackage

FILE: rtl/core/gqyi_in_if.sv
// Sample channel: one raw three-axis gyro sample per beat.
interface gqyi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

FILE: rtl/core/gqyi_out_if.sv
// Result channel: normalized attitude, yaw and reset flag per beat.
interface gqyi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [24:0] yaw_angle;
  logic               norm_reset;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  output yaw_angle, output norm_reset, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                input yaw_angle, input norm_reset, output ready);
endinterface

FILE: rtl/core/gqyi_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle.
module gqyi_mul import gqyi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic signed [37:0] a_q;
  logic [31:0]        b_q;
  logic signed [38:0] hi_q;
  logic [31:0]        lo_q;
  logic [4:0]         cnt_q;
  logic               busy_q;
  logic               done_q;

  logic signed [38:0] a_ext;
  logic signed [38:0] addend;
  logic signed [38:0] sum;

  assign a_ext = {a_q[37], a_q};

  // The top bit of the multiplier carries negative weight.
  always_comb begin
    if (!b_q[0]) begin
      addend = '0;
    end else if (cnt_q == 5'd31) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
  end

  assign sum = hi_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      b_q  <= req_i.b;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= {sum[38], sum[38:1]};
      lo_q <= {sum[0], lo_q[31:1]};
      b_q  <= {1'b0, b_q[31:1]};
    end
  end

  logic [70:0] prod_full;
  assign prod_full = {hi_q, lo_q};

  assign rsp_o.done = done_q;
  assign rsp_o.p    = prod_full[69:0];

endmodule

FILE: rtl/core/gyro_quaternion_yaw_integrator_core.sv
// Gyro quaternion yaw integrator: rate scaling, Euler step, renormalization, CORDIC yaw.
// Each sample uses up to 31 products of the shared bit-serial multiplier, a 32-step
// square root, four 31-step divisions and CORDIC_ITERS vectoring steps. The norm test
// squares are needed only when all components are tiny; a fallback of the attitude to
// identity skips the square root and the divisions. One sample is in work at a time.
// Reset returns control to idle, configuration to defaults and the attitude to identity.
module gyro_quaternion_yaw_integrator_core import gqyi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gqyi_in_if.sink     sample_i,
  gqyi_out_if.source  result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register map, one 32-bit word per register.
  localparam logic [2:0] REG_BIAS_X    = 3'd0;
  localparam logic [2:0] REG_BIAS_Y    = 3'd1;
  localparam logic [2:0] REG_BIAS_Z    = 3'd2;
  localparam logic [2:0] REG_RATE_SCL  = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND = 3'd4;
  localparam logic [2:0] REG_TIME_STEP = 3'd5;

  // The sequencer walks through the whole computation of one sample. Every
  // multiplying state issues a product to the shared multiplier and waits for it.
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RATE = 14'b00000000000010,
    S_SUM  = 14'b00000000000100,
    S_STEP = 14'b00000000001000,
    S_TEST = 14'b00000000010000,
    S_CHK  = 14'b00000000100000,
    S_NORM = 14'b00000001000000,
    S_NSQ  = 14'b00000010000000,
    S_SQRT = 14'b00000100000000,
    S_DIV  = 14'b00001000000000,
    S_YAWM = 14'b00010000000000,
    S_CPRE = 14'b00100000000000,
    S_CORD = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  // One term of the quaternion product q * [0, omega].
  typedef struct packed {
    logic [1:0] att_sel;
    logic [1:0] g_sel;
    logic       neg;
    logic       last;
    logic [1:0] comp;
  } term_t;

  function automatic term_t term_of(input logic [3:0] idx);
    term_t t;
    t = '0;
    unique case (idx)
      4'd0:    t = '{2'd1, 2'd0, 1'b1, 1'b0, 2'd0};
      4'd1:    t = '{2'd2, 2'd1, 1'b1, 1'b0, 2'd0};
      4'd2:    t = '{2'd3, 2'd2, 1'b1, 1'b1, 2'd0};
      4'd3:    t = '{2'd0, 2'd0, 1'b0, 1'b0, 2'd1};
      4'd4:    t = '{2'd2, 2'd2, 1'b0, 1'b0, 2'd1};
      4'd5:    t = '{2'd3, 2'd1, 1'b1, 1'b1, 2'd1};
      4'd6:    t = '{2'd0, 2'd1, 1'b0, 1'b0, 2'd2};
      4'd7:    t = '{2'd1, 2'd2, 1'b1, 1'b0, 2'd2};
      4'd8:    t = '{2'd3, 2'd0, 1'b0, 1'b1, 2'd2};
      4'd9:    t = '{2'd0, 2'd2, 1'b0, 1'b0, 2'd3};
      4'd10:   t = '{2'd1, 2'd1, 1'b0, 1'b0, 2'd3};
      4'd11:   t = '{2'd2, 2'd0, 1'b1, 1'b1, 2'd3};
      default: t = '0;
    endcase
    return t;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                 input int unsigned s);
    logic [71:0] m;
    logic [71:0] r;
    m = v[71] ? 72'(-v) : 72'(v);
    r = (m + (72'd1 << (s - 1))) >> s;
    return v[71] ? -$signed(r) : $signed(r);
  endfunction

  // Configuration registers.
  logic signed [23:0] bias_q [3];
  logic [23:0]        scale_q;
  logic [19:0]        db_q;
  logic [23:0]        ts_q;

  // Sequencer and datapath registers.
  state_e             state_q, state_d;
  logic [3:0]         idx_q, idx_d;
  logic               busy_q, busy_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [15:0] raw_q [3];
  logic signed [15:0] raw_d [3];
  logic signed [25:0] g_q [3];
  logic signed [25:0] g_d [3];
  logic signed [31:0] att_q [4];
  logic signed [31:0] att_d [4];
  logic signed [36:0] s_q [4];
  logic signed [36:0] s_d [4];
  logic signed [42:0] v_q [4];
  logic signed [42:0] v_d [4];
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] acc2_q, acc2_d;
  logic               flag_q, flag_d;
  logic [63:0]        sq_q, sq_d;
  logic [31:0]        root_q, root_d;
  logic [33:0]        srem_q, srem_d;
  logic [31:0]        drem_q, drem_d;
  logic [30:0]        dnum_q, dnum_d;
  logic [30:0]        quo_q, quo_d;
  logic signed [35:0] cx_q, cx_d;
  logic signed [35:0] cy_q, cy_d;
  logic signed [33:0] ang_q, ang_d;
  logic signed [24:0] yaw_q, yaw_d;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic signed [31:0] oquat_q [4];
  logic signed [31:0] oquat_d [4];
  logic signed [24:0] oyaw_q, oyaw_d;
  logic               oflag_q, oflag_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  gqyi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  // APB port: writes land on the access cycle, reads are combinational.
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_BIAS_X:    prdata = {{8{bias_q[0][23]}}, bias_q[0]};
      REG_BIAS_Y:    prdata = {{8{bias_q[1][23]}}, bias_q[1]};
      REG_BIAS_Z:    prdata = {{8{bias_q[2][23]}}, bias_q[2]};
      REG_RATE_SCL:  prdata = {8'd0, scale_q};
      REG_DEAD_BAND: prdata = {12'd0, db_q};
      REG_TIME_STEP: prdata = {8'd0, ts_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= '{24'sd0, 24'sd0, 24'sd0};
      scale_q <= 24'd4575231;
      db_q    <= 20'd9830;
      ts_q    <= 24'd83886;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BIAS_X:    bias_q[0] <= pwdata[23:0];
        REG_BIAS_Y:    bias_q[1] <= pwdata[23:0];
        REG_BIAS_Z:    bias_q[2] <= pwdata[23:0];
        REG_RATE_SCL:  scale_q   <= pwdata[23:0];
        REG_DEAD_BAND: db_q      <= pwdata[19:0];
        REG_TIME_STEP: ts_q      <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath helpers. The product of the multiplier is sign extended once and
  // then rounded or accumulated where each state needs it.
  logic signed [71:0] mp72;
  logic signed [63:0] mp64;
  assign mp72 = {{2{mrsp.p[69]}}, mrsp.p};
  assign mp64 = mrsp.p[63:0];

  term_t term;
  assign term = term_of(idx_q);

  logic signed [24:0] d_cur;
  assign d_cur = {raw_q[idx_q[1:0]][15], raw_q[idx_q[1:0]], 8'd0}
               - {bias_q[idx_q[1:0]][23], bias_q[idx_q[1:0]]};

  // Scaled rate with the dead band applied.
  logic signed [71:0] w_r;
  logic [71:0]        w_m;
  logic signed [25:0] g_new;
  assign w_r   = rnd_shr(mp72, 24);
  assign w_m   = w_r[71] ? 72'(-w_r) : 72'(w_r);
  assign g_new = (w_m < {52'd0, db_q}) ? 26'sd0 : w_r[25:0];

  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_add;
  logic signed [63:0] acc2_add;
  logic signed [71:0] s_r;
  assign acc_sum  = term.neg ? acc_q - mp64 : acc_q + mp64;
  assign acc_add  = acc_q + mp64;
  assign acc2_add = acc2_q + mp64;
  assign s_r      = rnd_shr({{8{acc_sum[63]}}, acc_sum}, 22);

  // Euler step increment and updated component.
  logic signed [71:0] t_r;
  logic signed [42:0] v_new;
  assign t_r   = rnd_shr(mp72, 19);
  assign v_new = {{11{att_q[idx_q[1:0]][31]}}, att_q[idx_q[1:0]]} + t_r[42:0];

  logic [42:0] vmag [4];
  logic        any_big;
  logic        all_tiny;
  logic        all_low;
  always_comb begin
    any_big  = 1'b0;
    all_tiny = 1'b1;
    all_low  = 1'b1;
    for (int i = 0; i < 4; i++) begin
      vmag[i] = v_q[i][42] ? 43'(-v_q[i]) : 43'(v_q[i]);
      if (vmag[i][42:31] != '0) any_big = 1'b1;
      if (vmag[i][42:17] != '0) all_tiny = 1'b0;
      if (vmag[i][42:30] != '0) all_low = 1'b0;
    end
  end

  logic [30:0] vm_cur;
  assign vm_cur = vmag[idx_q[1:0]][30:0];

  // Square root digit step, two radicand bits a cycle.
  logic [35:0] sq_rs;
  logic [35:0] sq_trial;
  logic        sq_ge;
  assign sq_rs    = {srem_q, sq_q[63:62]};
  assign sq_trial = {2'd0, root_q, 2'b01};
  assign sq_ge    = sq_rs >= sq_trial;

  // Restoring division of the rounded, shifted magnitude by the root.
  logic [61:0] dnum_full;
  logic [32:0] div_t;
  logic        div_ge;
  logic [32:0] div_sub;
  logic [30:0] quo_fin;
  assign dnum_full = {vm_cur, 31'd0} >> 1;
  logic [61:0] dnum_rnd;
  assign dnum_rnd = dnum_full + {31'd0, root_q[31:1]};
  assign div_t    = {drem_q, dnum_q[30]};
  assign div_ge   = div_t >= {1'b0, root_q};
  assign div_sub  = div_t - {1'b0, root_q};
  assign quo_fin  = {quo_q[29:0], div_ge};

  // Yaw operands: sine and cosine terms scaled back from Q.60.
  logic signed [63:0] cs_full;
  logic signed [63:0] sn_sh;
  logic signed [63:0] cs_sh;
  logic signed [34:0] sn;
  logic signed [34:0] cs;
  assign cs_full = (64'sd1 <<< 59) - acc2_q;
  assign sn_sh   = acc_q >>> 29;
  assign cs_sh   = cs_full >>> 29;
  assign sn      = sn_sh[34:0];
  assign cs      = cs_sh[34:0];

  // CORDIC vectoring step.
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [33:0] tab;
  logic signed [33:0] ang_nxt;
  logic signed [71:0] yaw_r;
  logic signed [24:0] yaw_cl;
  assign xs      = cx_q >>> cnt_q;
  assign ys      = cy_q >>> cnt_q;
  assign tab     = {4'd0, ATAN_TAB[cnt_q]};
  assign ang_nxt = (cy_q > 0) ? ang_q + tab : ang_q - tab;
  assign yaw_r   = rnd_shr({{38{ang_nxt[33]}}, ang_nxt}, 8);

  always_comb begin
    if (yaw_r > 72'(YAW_MAX)) begin
      yaw_cl = YAW_MAX;
    end else if (yaw_r < -72'(YAW_MAX)) begin
      yaw_cl = -YAW_MAX;
    end else begin
      yaw_cl = yaw_r[24:0];
    end
  end

  // Multiplier operand selection.
  logic mul_state;
  assign mul_state = (state_q == S_RATE) || (state_q == S_SUM) || (state_q == S_STEP) ||
                     (state_q == S_CHK) || (state_q == S_NSQ) || (state_q == S_YAWM);

  logic [1:0] ya_sel;
  logic [1:0] yb_sel;
  always_comb begin
    unique case (idx_q[1:0])
      2'd0: begin
        ya_sel = 2'd0;
        yb_sel = 2'd3;
      end
      2'd1: begin
        ya_sel = 2'd1;
        yb_sel = 2'd2;
      end
      2'd2: begin
        ya_sel = 2'd2;
        yb_sel = 2'd2;
      end
      default: begin
        ya_sel = 2'd3;
        yb_sel = 2'd3;
      end
    endcase
  end

  always_comb begin
    mreq       = '0;
    mreq.start = mul_state && !busy_q;
    unique case (state_q)
      S_RATE: begin
        mreq.a = {{13{d_cur[24]}}, d_cur};
        mreq.b = {8'd0, scale_q};
      end
      S_SUM: begin
        mreq.a = {{6{att_q[term.att_sel][31]}}, att_q[term.att_sel]};
        mreq.b = {{6{g_q[term.g_sel][25]}}, g_q[term.g_sel]};
      end
      S_STEP: begin
        mreq.a = {s_q[idx_q[1:0]][36], s_q[idx_q[1:0]]};
        mreq.b = {8'd0, ts_q};
      end
      S_CHK: begin
        mreq.a = {21'd0, vm_cur[16:0]};
        mreq.b = {15'd0, vm_cur[16:0]};
      end
      S_NSQ: begin
        mreq.a = {7'd0, vm_cur};
        mreq.b = {1'b0, vm_cur};
      end
      S_YAWM: begin
        mreq.a = {{6{att_q[ya_sel][31]}}, att_q[ya_sel]};
        mreq.b = att_q[yb_sel];
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  assign sample_i.ready = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    raw_d    = raw_q;
    g_d      = g_q;
    att_d    = att_q;
    s_d      = s_q;
    v_d      = v_q;
    acc_d    = acc_q;
    acc2_d   = acc2_q;
    flag_d   = flag_q;
    sq_d     = sq_q;
    root_d   = root_q;
    srem_d   = srem_q;
    drem_d   = drem_q;
    dnum_d   = dnum_q;
    quo_d    = quo_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    ang_d    = ang_q;
    yaw_d    = yaw_q;
    oquat_d  = oquat_q;
    oyaw_d   = oyaw_q;
    oflag_d  = oflag_q;
    ovalid_d = ovalid_q;

    if (ovalid_q && result_o.ready) begin
      ovalid_d = 1'b0;
    end

    if (mul_state && !busy_q) begin
      busy_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          raw_d   = '{sample_i.rate_x, sample_i.rate_y, sample_i.rate_z};
          idx_d   = '0;
          busy_d  = 1'b0;
          state_d = S_RATE;
        end
      end
      S_RATE: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          g_d[idx_q[1:0]] = g_new;
          if (idx_q == 4'd2) begin
            idx_d   = '0;
            acc_d   = '0;
            state_d = S_SUM;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_SUM: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          if (term.last) begin
            s_d[term.comp] = s_r[36:0];
            acc_d = '0;
          end else begin
            acc_d = acc_sum;
          end
          if (idx_q == 4'd11) begin
            idx_d   = '0;
            state_d = S_STEP;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_STEP: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          v_d[idx_q[1:0]] = v_new;
          if (idx_q == 4'd3) begin
            idx_d   = '0;
            state_d = S_TEST;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_TEST: begin
        // Only tiny components can give a sum of squares below the threshold.
        acc_d = '0;
        idx_d = '0;
        if (!any_big && all_tiny) begin
          state_d = S_CHK;
        end else begin
          flag_d  = 1'b0;
          state_d = S_NORM;
        end
      end
      S_CHK: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          acc_d  = acc_add;
          if (idx_q == 4'd3) begin
            idx_d = '0;
            acc_d = '0;
            if ($unsigned(acc_add) < NORM_SQ_MIN) begin
              flag_d  = 1'b1;
              att_d   = '{ONE_Q30, 32'sd0, 32'sd0, 32'sd0};
              state_d = S_YAWM;
            end else begin
              flag_d  = 1'b0;
              state_d = S_NORM;
            end
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_NORM: begin
        // One power-of-two step a cycle until the largest magnitude is in [2^30, 2^31).
        if (any_big) begin
          for (int i = 0; i < 4; i++) v_d[i] = v_q[i] >>> 1;
        end else if (all_low) begin
          for (int i = 0; i < 4; i++) v_d[i] = v_q[i] <<< 1;
        end else begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = S_NSQ;
        end
      end
      S_NSQ: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          acc_d  = acc_add;
          if (idx_q == 4'd3) begin
            sq_d    = acc_add;
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = '0;
            state_d = S_SQRT;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_SQRT: begin
        sq_d  = {sq_q[61:0], 2'b00};
        cnt_d = cnt_q + 5'd1;
        if (sq_ge) begin
          srem_d = 34'(sq_rs - sq_trial);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          srem_d = sq_rs[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
        if (cnt_q == 5'd31) begin
          idx_d   = '0;
          busy_d  = 1'b0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!busy_q) begin
          busy_d = 1'b1;
          drem_d = {1'b0, dnum_rnd[61:31]};
          dnum_d = dnum_rnd[30:0];
          quo_d  = '0;
          cnt_d  = '0;
        end else begin
          drem_d = div_ge ? div_sub[31:0] : div_t[31:0];
          dnum_d = {dnum_q[29:0], 1'b0};
          quo_d  = quo_fin;
          cnt_d  = cnt_q + 5'd1;
          if (cnt_q == 5'd30) begin
            busy_d = 1'b0;
            att_d[idx_q[1:0]] = v_q[idx_q[1:0]][42] ? -$signed({1'b0, quo_fin})
                                                    : $signed({1'b0, quo_fin});
            if (idx_q == 4'd3) begin
              idx_d   = '0;
              state_d = S_YAWM;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
        end
      end
      S_YAWM: begin
        if (busy_q && mrsp.done) begin
          busy_d = 1'b0;
          unique case (idx_q[1:0])
            2'd0:    acc_d  = mp64;
            2'd1:    acc_d  = acc_add;
            2'd2:    acc2_d = mp64;
            default: acc2_d = acc2_add;
          endcase
          if (idx_q == 4'd3) begin
            state_d = S_CPRE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_CPRE: begin
        // A zero cosine term gives +-90 degrees or zero without CORDIC; a
        // negative one is turned by 90 degrees into the right half plane.
        cnt_d = '0;
        if (cs == 35'sd0) begin
          if (sn > 35'sd0) begin
            yaw_d = YAW_90;
          end else if (sn < 35'sd0) begin
            yaw_d = -YAW_90;
          end else begin
            yaw_d = '0;
          end
          state_d = S_DONE;
        end else begin
          if (cs < 35'sd0) begin
            if (sn >= 35'sd0) begin
              cx_d  = 36'(sn);
              cy_d  = -36'(cs);
              ang_d = DEG90_Q24;
            end else begin
              cx_d  = -36'(sn);
              cy_d  = 36'(cs);
              ang_d = -DEG90_Q24;
            end
          end else begin
            cx_d  = 36'(cs);
            cy_d  = 36'(sn);
            ang_d = '0;
          end
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (cy_q > 0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
        end
        ang_d = ang_nxt;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_ITERS - 1)) begin
          yaw_d   = yaw_cl;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ovalid_q || result_o.ready) begin
          oquat_d  = att_q;
          oyaw_d   = yaw_q;
          oflag_d  = flag_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      att_q    <= '{ONE_Q30, 32'sd0, 32'sd0, 32'sd0};
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      att_q    <= att_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    g_q     <= g_d;
    s_q     <= s_d;
    v_q     <= v_d;
    acc_q   <= acc_d;
    acc2_q  <= acc2_d;
    flag_q  <= flag_d;
    sq_q    <= sq_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    drem_q  <= drem_d;
    dnum_q  <= dnum_d;
    quo_q   <= quo_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    ang_q   <= ang_d;
    yaw_q   <= yaw_d;
    oquat_q <= oquat_d;
    oyaw_q  <= oyaw_d;
    oflag_q <= oflag_d;
  end

  assign result_o.valid      = ovalid_q;
  assign result_o.quat_w     = oquat_q[0];
  assign result_o.quat_x     = oquat_q[1];
  assign result_o.quat_y     = oquat_q[2];
  assign result_o.quat_z     = oquat_q[3];
  assign result_o.yaw_angle  = oyaw_q;
  assign result_o.norm_reset = oflag_q;

endmodule
